### sv/riscv_relocation_patcher_defines.svh
// ----------------------------------------------------------------------------
// RISC-V relocation patcher: assertion macros
// Shared concurrent assertion forms, all disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RISCV_RELOCATION_PATCHER_DEFINES_SVH
`define RISCV_RELOCATION_PATCHER_DEFINES_SVH

// Same-cycle implication
`define RRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rrp: same-cycle check failed");

// Next-cycle implication
`define RRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rrp: next-cycle check failed");

`endif

### sv/rrp_pkg.sv
// ----------------------------------------------------------------------------
// RISC-V relocation patcher package
// Item types, relocation and symbol class codes, register indexes.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Relocation type codes
  localparam logic [7:0] RT_WORD32   = 8'd1;
  localparam logic [7:0] RT_BRANCH   = 8'd16;
  localparam logic [7:0] RT_JAL      = 8'd17;
  localparam logic [7:0] RT_CALL     = 8'd18;
  localparam logic [7:0] RT_CALL_PLT = 8'd19;
  localparam logic [7:0] RT_HI20     = 8'd26;
  localparam logic [7:0] RT_LO12_I   = 8'd27;
  localparam logic [7:0] RT_LO12_S   = 8'd28;
  localparam logic [7:0] RT_ALIGN    = 8'd43;
  localparam logic [7:0] RT_RELAX    = 8'd51;

  // Symbol classes
  localparam logic [1:0] CLS_ABS      = 2'd0;
  localparam logic [1:0] CLS_UNPLACED = 2'd1;
  localparam logic [1:0] CLS_EXEC     = 2'd2;
  localparam logic [1:0] CLS_DATA     = 2'd3;

  // Configuration register indexes
  localparam logic CFG_EXEC_BASE = 1'b0;
  localparam logic CFG_DATA_BASE = 1'b1;

  // Input item
  typedef struct packed {
    logic [7:0]         reloc_type;
    logic [1:0]         symbol_class;
    logic [31:0]        section_offset;
    logic [31:0]        symbol_value;
    logic signed [31:0] addend;
    logic [31:0]        place_address;
    logic [31:0]        first_word;
    logic [31:0]        second_word;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] patched_first;
    logic [31:0] patched_second;
    logic        write_first;
    logic        write_second;
    logic        status;
  } out_item_t;

  // Stage 1 -> stage 2: partial sums
  typedef struct packed {
    logic        valid;
    logic [7:0]  reloc_type;
    logic [31:0] region_sum;
    logic [31:0] value_sum;
    logic [31:0] place_address;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } s1_t;

  // Stage 2 -> stage 3: target and pc-relative offset
  typedef struct packed {
    logic        valid;
    logic [7:0]  reloc_type;
    logic [31:0] target;
    logic [31:0] offset;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } s2_t;

endpackage

### sv/riscv_relocation_patcher.sv
// ----------------------------------------------------------------------------
// RISC-V relocation patcher
// Pipeline: three register stages, resolve, sum and pack.
// Throughput: one item per cycle with no output stall; the adders of stages 1
// and 2 and the packer of stage 3 each take one; a stall holds only full stages.
// Reset: asynchronous, active low; clears stage valid bits and both region bases.
// ----------------------------------------------------------------------------
`include "riscv_relocation_patcher_defines.svh"

module riscv_relocation_patcher import rrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Relocation items in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // Patched items out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] exec_base_q;
  logic [31:0] data_base_q;
  logic        s1_ready;
  logic        s2_ready;
  logic        s3_ready;
  s1_t         s1;
  s2_t         s2;

  assign cfg_ready_o = 1'b1;

  // Region base registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_base_q <= 32'd0;
      data_base_q <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_EXEC_BASE: exec_base_q <= cfg_data_i;
        CFG_DATA_BASE: data_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !s1_ready;

  // Pipeline stages
  rrp_resolve u_resolve (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .item_i       (in_item_i),
    .exec_base_i  (exec_base_q),
    .data_base_i  (data_base_q),
    .down_ready_i (s2_ready),
    .ready_o      (s1_ready),
    .stage_o      (s1)
  );

  rrp_sum u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (s1),
    .down_ready_i (s3_ready),
    .ready_o      (s2_ready),
    .stage_o      (s2)
  );

  rrp_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (s2),
    .out_stall_i (out_stall_i),
    .ready_o     (s3_ready),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // Checks
  `RRP_ASSERT_IMP(a_unsup_no_write, clk_i, rst_ni, out_valid_o && out_item_o.status,
                  !out_item_o.write_first && !out_item_o.write_second)
  `RRP_ASSERT_IMP(a_second_needs_first, clk_i, rst_ni,
                  out_valid_o && out_item_o.write_second, out_item_o.write_first)
  `RRP_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o,
                  s1.valid && s2.valid && out_valid_o && out_stall_i)
  `RRP_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, s1.valid)

endmodule

### sv/rrp_resolve.sv
// ----------------------------------------------------------------------------
// Stage 1: symbol resolution
// Region base plus section offset, and symbol value plus addend.
// ----------------------------------------------------------------------------
module rrp_resolve import rrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  in_item_t    item_i,
  input  logic [31:0] exec_base_i,
  input  logic [31:0] data_base_i,
  input  logic        down_ready_i,
  output logic        ready_o,
  output s1_t         stage_o
);

  s1_t         stage_q;
  logic        valid_d;
  logic [31:0] region_d;
  logic [31:0] value_d;
  logic [31:0] base_sel;
  logic [31:0] value_sel;

  assign ready_o = !stage_q.valid || down_ready_i;
  assign valid_d = valid_i;

  // Region term is zero for absolute and unplaced symbols
  always_comb begin
    base_sel = (item_i.symbol_class == CLS_EXEC) ? exec_base_i : data_base_i;
    region_d = item_i.symbol_class[1] ? (base_sel + item_i.section_offset) : 32'd0;
    value_sel = (item_i.symbol_class == CLS_UNPLACED) ? 32'd0 : item_i.symbol_value;
    value_d = value_sel + $unsigned(item_i.addend);
  end

  // Stage register; only the valid bit is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (ready_o) begin
      stage_q.valid <= valid_d;
      if (valid_i) begin
        stage_q.reloc_type    <= item_i.reloc_type;
        stage_q.region_sum    <= region_d;
        stage_q.value_sum     <= value_d;
        stage_q.place_address <= item_i.place_address;
        stage_q.first_word    <= item_i.first_word;
        stage_q.second_word   <= item_i.second_word;
      end
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/rrp_sum.sv
// ----------------------------------------------------------------------------
// Stage 2: target and offset
// Final target address and its offset from the place.
// ----------------------------------------------------------------------------
module rrp_sum import rrp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  s1_t  stage_i,
  input  logic down_ready_i,
  output logic ready_o,
  output s2_t  stage_o
);

  s2_t         stage_q;
  logic [31:0] target_d;
  logic [31:0] offset_d;

  assign ready_o = !stage_q.valid || down_ready_i;

  // Offset as one three-input add
  always_comb begin
    target_d = stage_i.region_sum + stage_i.value_sum;
    offset_d = stage_i.region_sum + stage_i.value_sum - stage_i.place_address;
  end

  // Stage register; only the valid bit is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (ready_o) begin
      stage_q.valid <= stage_i.valid;
      if (stage_i.valid) begin
        stage_q.reloc_type  <= stage_i.reloc_type;
        stage_q.target      <= target_d;
        stage_q.offset      <= offset_d;
        stage_q.first_word  <= stage_i.first_word;
        stage_q.second_word <= stage_i.second_word;
      end
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/rrp_pack.sv
// ----------------------------------------------------------------------------
// Stage 3: instruction patching
// Packs target or offset into the immediate layout of the type; output register.
// ----------------------------------------------------------------------------
module rrp_pack import rrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  s2_t       stage_i,
  input  logic      out_stall_i,
  output logic      ready_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  logic      valid_q;
  out_item_t item_q;
  out_item_t item_d;
  logic [31:0] hi_target;
  logic [31:0] hi_offset;

  // U-type upper immediate with rounding
  function automatic logic [31:0] put_hi20(logic [31:0] word, logic [31:0] v);
    logic [31:0] r;
    r = v + 32'h0000_0800;
    return {r[31:12], word[11:0]};
  endfunction

  function automatic logic [31:0] put_lo12_i(logic [31:0] word, logic [31:0] v);
    return {v[11:0], word[19:0]};
  endfunction

  function automatic logic [31:0] put_lo12_s(logic [31:0] word, logic [31:0] v);
    return {v[11:5], word[24:12], v[4:0], word[6:0]};
  endfunction

  function automatic logic [31:0] put_jal(logic [31:0] word, logic [31:0] off);
    return {off[20], off[10:1], off[11], off[19:12], word[11:0]};
  endfunction

  function automatic logic [31:0] put_branch(logic [31:0] word, logic [31:0] off);
    return {off[12], off[10:5], word[24:12], off[4:1], off[11], word[6:0]};
  endfunction

  assign ready_o   = !valid_q || !out_stall_i;
  assign hi_target = put_hi20(stage_i.first_word, stage_i.target);
  assign hi_offset = put_hi20(stage_i.first_word, stage_i.offset);

  // Type decoder
  always_comb begin
    item_d.patched_first  = stage_i.first_word;
    item_d.patched_second = stage_i.second_word;
    item_d.write_first    = 1'b1;
    item_d.write_second   = 1'b0;
    item_d.status         = 1'b0;
    unique case (stage_i.reloc_type) inside
      RT_WORD32:  item_d.patched_first = stage_i.target;
      RT_HI20:    item_d.patched_first = hi_target;
      RT_LO12_I:  item_d.patched_first = put_lo12_i(stage_i.first_word, stage_i.target);
      RT_LO12_S:  item_d.patched_first = put_lo12_s(stage_i.first_word, stage_i.target);
      RT_CALL, RT_CALL_PLT: begin
        item_d.patched_first  = hi_offset;
        item_d.patched_second = put_lo12_i(stage_i.second_word, stage_i.offset);
        item_d.write_second   = 1'b1;
      end
      RT_JAL:     item_d.patched_first = put_jal(stage_i.first_word, stage_i.offset);
      RT_BRANCH:  item_d.patched_first = put_branch(stage_i.first_word, stage_i.offset);
      RT_ALIGN, RT_RELAX: item_d.write_first = 1'b0;
      default: begin
        item_d.write_first = 1'b0;
        item_d.status      = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && stage_i.valid) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
